// File: hdl/afsr_pkg.sv
// Package for the adaptive force-sensor press classifier.
// Types, gesture codes, register indexes and the controller state enum.
`default_nettype none
package afsr_pkg;
  localparam int unsigned CFG_BITS = 20;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam logic [CFG_IDX_BITS-1:0] REG_LONG_PRESS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF    = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_CALIB      = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_FACTOR     = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_FLOOR      = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW     = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] REG_INIT_THR   = 3'd6;

  localparam logic [2:0] G_VOL_DOWN = 3'd0;
  localparam logic [2:0] G_VOL_UP   = 3'd1;
  localparam logic [2:0] G_ASSIST   = 3'd2;
  localparam logic [2:0] G_NEXT     = 3'd3;
  localparam logic [2:0] G_PREV     = 3'd4;
  localparam logic [2:0] G_PLAY     = 3'd5;

  localparam logic [12:0] THR_MAX = 13'd8191;

  typedef enum logic [2:0] {
    ST_IDLE, ST_SAMPLE, ST_DIV, ST_THR, ST_DECIDE, ST_OUT
  } afsr_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item
    logic sample;    // classify samples, update sums, start divider
    logic div_step;  // one divider step
    logic thr_write; // write thresholds from quotient
    logic decide;    // run gesture logic
    logic pop;       // drop the head result
  } afsr_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
    logic has_out;
  } afsr_sts_t;
endpackage
`default_nettype wire

// File: hdl/adaptive_fsr_press_gesture_classifier.sv
// Adaptive force-sensor press gesture classifier, top level.
// Uses afsr_pkg, afsr_ctrl and afsr_datapath.
//
// Input channel (in_valid/in_ready) carries one item: a right and left
// force sample, a millisecond timestamp and a link-up flag. Output channel
// (out_valid/out_ready) carries up to two gesture items per input, the
// final one with last set. Configuration is a write-only port (cfg_we,
// cfg_index, cfg_data) that the user must write only while it is idle.
//
// Each item passes through the accepting state, classify and update idle
// sums (skipped for an item in holdoff), 42 steps of a restoring divider
// for the mean threshold (sum times factor over count times 256, both
// channels in parallel), a threshold write and a decision step, then the
// results drain until the queue is empty. One item is in flight at a time;
// in_ready is high only when the previous item's results are all taken.
// The block itself does not enforce that configuration is written only
// while it is idle.
// Reset restores default registers, thresholds at the initial value and
// empty statistics. A stalled receiver holds the block in its drain state
// with the current gesture steady on the output.
`default_nettype none
module adaptive_fsr_press_gesture_classifier import afsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]     cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic [SAMPLE_BITS-1:0]  adc_right,
  input  wire logic [SAMPLE_BITS-1:0]  adc_left,
  input  wire logic [31:0]             now_ms,
  input  wire logic                    link_up,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [2:0]                   gesture,
  output logic                         last
);
  afsr_cmd_t cmd;
  afsr_sts_t sts;

  // sequencing
  afsr_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_ready, .out_valid, .sts, .cmd
  );

  // statistics, divider, gesture rules and result queue
  afsr_datapath #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .adc_right, .adc_left, .now_ms, .link_up,
    .cmd, .sts, .gesture, .last
  );
endmodule
`default_nettype wire

// File: hdl/afsr_ctrl.sv
// Controller state machine for the press classifier.
// Depends on afsr_pkg; drives afsr_datapath through afsr_cmd_t.
`default_nettype none
module afsr_ctrl import afsr_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire logic      out_ready,
  output logic           out_valid,
  input  wire afsr_sts_t sts,
  output afsr_cmd_t      cmd
);
  afsr_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_SAMPLE;
      ST_SAMPLE: state_next = ST_DIV;
      ST_DIV:    if (sts.div_done) state_next = ST_THR;
      ST_THR:    state_next = ST_DECIDE;
      ST_DECIDE: state_next = ST_OUT;
      ST_OUT:    if (!sts.has_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SAMPLE: cmd.sample = 1'b1;
      ST_DIV:    cmd.div_step = 1'b1;
      ST_THR:    cmd.thr_write = 1'b1;
      ST_DECIDE: cmd.decide = 1'b1;
      ST_OUT: begin
        out_valid = sts.has_out;
        cmd.pop = sts.has_out & out_ready;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: hdl/afsr_datapath.sv
// Datapath: idle statistics, restoring dividers, gesture state and result queue.
// Depends on afsr_pkg; sequenced by afsr_ctrl.
`default_nettype none
module afsr_datapath import afsr_pkg::*; #(
  parameter int unsigned SAMPLE_BITS = 12,
  parameter int unsigned COUNT_BITS = 20
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]    cfg_data,
  input  wire logic [SAMPLE_BITS-1:0] adc_right,
  input  wire logic [SAMPLE_BITS-1:0] adc_left,
  input  wire logic [31:0]            now_ms,
  input  wire logic                   link_up,
  input  wire afsr_cmd_t              cmd,
  output afsr_sts_t                   sts,
  output logic [2:0]                  gesture,
  output logic                        last
);
  localparam int unsigned NUM_BITS = 42;            // 32-bit sum times 10-bit factor
  localparam int unsigned DEN_BITS = COUNT_BITS + 8;
  localparam int unsigned STEP_BITS = $clog2(NUM_BITS + 1);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // configuration
  logic [15:0] long_press_ms, holdoff_ms, gesture_window_ms;
  logic [19:0] calibration_ms;
  logic [9:0]  factor_q8;
  logic [11:0] thr_floor;
  logic [12:0] init_thr;

  always_ff @(posedge clk) begin
    if (rst) begin
      long_press_ms <= 16'd2000; holdoff_ms <= 16'd500; calibration_ms <= 20'd10000;
      factor_q8 <= 10'd307; thr_floor <= 12'd300; gesture_window_ms <= 16'd500;
      init_thr <= 13'd3600;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_LONG_PRESS: long_press_ms <= cfg_data[15:0];
        REG_HOLDOFF:    holdoff_ms <= cfg_data[15:0];
        REG_CALIB:      calibration_ms <= cfg_data[19:0];
        REG_FACTOR:     factor_q8 <= cfg_data[9:0];
        REG_FLOOR:      thr_floor <= cfg_data[11:0];
        REG_WINDOW:     gesture_window_ms <= cfg_data[15:0];
        REG_INIT_THR:   init_thr <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // captured item
  logic [SAMPLE_BITS-1:0] smp [2];
  logic [31:0] now;
  logic link;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      smp[0] <= adc_right; smp[1] <= adc_left; now <= now_ms; link <= link_up;
    end
  end

  // per-channel state
  logic [12:0] press_thr [2];
  logic [31:0] idle_sum [2];
  logic [COUNT_BITS-1:0] idle_count [2];
  logic [1:0] pn, pb, lf, df, fv;
  logic [31:0] pst [2], rel [2], fpt [2], ldur [2];
  logic [7:0] tally [2];
  logic handled;
  logic [31:0] holdoff_until;
  logic skip;       // item lies in holdoff
  logic [1:0] upd;  // threshold to be rewritten

  // dividers, one per channel, stepped together
  logic [NUM_BITS-1:0] quo [2];
  logic [DEN_BITS:0]   rem [2];
  logic [DEN_BITS-1:0] den [2];
  logic [STEP_BITS-1:0] step;

  assign sts.div_done = (step == STEP_BITS'(NUM_BITS - 1));

  // result queue (at most two)
  logic [2:0] q_g [2];
  logic [1:0] q_n;
  logic q_head;
  assign sts.has_out = (q_n != 2'd0);
  assign gesture = q_g[q_head];
  assign last = (q_n == 2'd1);

  // combinational pieces of the sample step
  logic [1:0] pn_c;
  logic [32:0] ns [2];
  logic [1:0] acc;
  logic in_hold;
  logic [31:0] hdiff;
  always_comb begin
    hdiff = holdoff_until - now - 32'd1;
    in_hold = (hdiff < 32'd65535);
    for (int c = 0; c < 2; c++) begin
      pn_c[c] = (32'(smp[c]) >= 32'((idle_count[c] == '0) ? init_thr : press_thr[c]));
      ns[c] = 33'(idle_sum[c]) + 33'(smp[c]);
      acc[c] = (idle_count[c] != COUNT_MAX) && !ns[c][32];
    end
  end

  // gesture decision, modeled on the sequential rules
  logic [1:0] pb_n, lf_n, df_n, fv_n;
  logic [31:0] pst_n [2], rel_n [2], fpt_n [2], ldur_n [2];
  logic [7:0] tally_n [2];
  logic handled_n, hold_set;
  logic [2:0] g0, g1;
  logic [1:0] cnt;
  logic done;
  always_comb begin
    pb_n = pb; lf_n = lf; df_n = df; fv_n = fv;
    pst_n = pst; rel_n = rel; fpt_n = fpt; ldur_n = ldur; tally_n = tally;
    handled_n = handled; hold_set = 1'b0; g0 = G_PLAY; g1 = G_PLAY; cnt = 2'd0;
    done = 1'b0;
    if (!link || now < 32'(calibration_ms)) done = 1'b1;
    if (!done) begin
      if (pn[0] && !pb[0]) begin
        pst_n[0] = now; pb_n = pn; done = 1'b1;
      end else if (pn[1] && !pb[1]) begin
        pst_n[1] = now; pb_n = pn; done = 1'b1;
      end
    end
    if (!done) begin
      if (pn[0] && pn[1]) begin
        if (now - pst[0] >= 32'(long_press_ms) && now - pst[1] >= 32'(long_press_ms)) begin
          g0 = G_ASSIST; cnt = 2'd1; hold_set = 1'b1; pb_n = pn; lf_n = 2'b11; done = 1'b1;
        end
      end else if (pn[1] && now - pst[1] >= 32'(long_press_ms)) begin
        g0 = G_VOL_DOWN; cnt = 2'd1; hold_set = 1'b1; pb_n = pn; lf_n[1] = 1'b1; done = 1'b1;
      end else if (pn[0] && now - pst[0] >= 32'(long_press_ms)) begin
        g0 = G_VOL_UP; cnt = 2'd1; hold_set = 1'b1; pb_n = pn; lf_n[0] = 1'b1; done = 1'b1;
      end
    end
    if (!done) begin
      for (int c = 0; c < 2; c++) begin
        if (!pn[c] && pb_n[c]) begin
          rel_n[c] = now;
          ldur_n[c] = now - pst[c];
          if (!lf_n[c]) begin
            handled_n = 1'b0;
            if (tally_n[c] != 8'd255) tally_n[c] = tally_n[c] + 8'd1;
          end else begin
            handled_n = 1'b1; pb_n = pn;
          end
          lf_n[c] = 1'b0;
        end
      end
      if (ldur_n[1] > 32'(long_press_ms) || ldur_n[0] > 32'(long_press_ms) || lf_n != 2'b00) begin
        lf_n = 2'b00; pb_n = pn; ldur_n[0] = '0; ldur_n[1] = '0; done = 1'b1;
      end else if (pn != 2'b00) begin
        done = 1'b1;
      end
    end
    if (!done && !handled_n) begin
      for (int c = 0; c < 2; c++) begin
        if (!done) begin
          if (!fv_n[c] && pb_n[c]) begin
            fpt_n[c] = now; fv_n[c] = 1'b1;
          end else if (!df_n[c] && fv_n[c] && now - fpt_n[c] <= 32'(gesture_window_ms)
                       && tally_n[c] >= 8'd2) begin
            df_n[c] = 1'b1;
            g0 = (c == 0) ? G_NEXT : G_PREV; cnt = 2'd1;
            hold_set = 1'b1; pb_n = pn; handled_n = 1'b1; tally_n[c] = '0; done = 1'b1;
          end
        end
      end
    end
    if (!done) begin
      for (int c = 0; c < 2; c++) begin
        if (!pn[c] && now - rel_n[c] >= 32'(gesture_window_ms) && fv_n[c]) begin
          if (tally_n[c] == 8'd1) begin
            if (cnt == 2'd0) g0 = G_PLAY; else g1 = G_PLAY;
            cnt = cnt + 2'd1;
          end
          handled_n = 1'b1; fpt_n[c] = '0; fv_n[c] = 1'b0; df_n[c] = 1'b0; tally_n[c] = '0;
        end
      end
      pb_n = pn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < 2; c++) begin
        idle_sum[c] <= '0; idle_count[c] <= '0; pst[c] <= '0; rel[c] <= '0;
        fpt[c] <= '0; ldur[c] <= '0; tally[c] <= '0;
      end
      pn <= '0; pb <= '0; lf <= '0; df <= '0; fv <= '0;
      handled <= 1'b1; holdoff_until <= '0; skip <= 1'b0; upd <= '0;
      q_n <= '0; q_head <= 1'b0; step <= '0;
    end else begin
      if (cmd.sample) begin
        skip <= in_hold;
        step <= '0;
        upd <= '0;
        if (!in_hold) begin
          pn <= pn_c;
          for (int c = 0; c < 2; c++) begin
            if (!pn_c[c]) begin
              logic [31:0] sum_u;
              logic [COUNT_BITS-1:0] cnt_u;
              sum_u = acc[c] ? ns[c][31:0] : idle_sum[c];
              cnt_u = acc[c] ? idle_count[c] + 1'b1 : idle_count[c];
              idle_sum[c] <= sum_u;
              idle_count[c] <= cnt_u;
              upd[c] <= (cnt_u != '0);
              quo[c] <= 42'(sum_u) * 42'(factor_q8);
              rem[c] <= '0;
              den[c] <= {cnt_u, 8'd0};
            end
          end
        end
      end
      if (cmd.div_step) begin
        step <= step + 1'b1;
        for (int c = 0; c < 2; c++) begin
          logic [DEN_BITS:0] r;
          r = {rem[c][DEN_BITS-1:0], quo[c][NUM_BITS-1]};
          if (r >= {1'b0, den[c]}) begin
            rem[c] <= r - {1'b0, den[c]};
            quo[c] <= {quo[c][NUM_BITS-2:0], 1'b1};
          end else begin
            rem[c] <= r;
            quo[c] <= {quo[c][NUM_BITS-2:0], 1'b0};
          end
        end
      end
      if (cmd.decide && !skip) begin
        pb <= pb_n; lf <= lf_n; df <= df_n; fv <= fv_n;
        pst <= pst_n; rel <= rel_n; fpt <= fpt_n; ldur <= ldur_n; tally <= tally_n;
        handled <= handled_n;
        if (hold_set) holdoff_until <= now + 32'(holdoff_ms);
        q_g[0] <= g0; q_g[1] <= g1; q_n <= cnt; q_head <= 1'b0;
      end
      if (cmd.pop) begin
        q_n <= q_n - 2'd1; q_head <= 1'b1;
      end
    end
  end

  // threshold write: clamp quotient to [floor, 8191]
  always_ff @(posedge clk) begin
    if (rst) begin
      press_thr[0] <= 13'd3600; press_thr[1] <= 13'd3600;
    end else if (cmd.thr_write && !skip) begin
      for (int c = 0; c < 2; c++) begin
        if (upd[c]) begin
          if (quo[c] < NUM_BITS'(thr_floor)) press_thr[c] <= 13'(thr_floor);
          else if (quo[c] > NUM_BITS'(THR_MAX)) press_thr[c] <= THR_MAX;
          else press_thr[c] <= quo[c][12:0];
        end
      end
    end
  end
endmodule
`default_nettype wire

// File: dv/adaptive_fsr_press_gesture_classifier_tb.sv
// Self-checking testbench for adaptive_fsr_press_gesture_classifier.
// Depends on afsr_pkg (register indexes, gesture codes) and the block's RTL.
// A behavioral predictor runs alongside the block and checks each gesture item.
`default_nettype none
module adaptive_fsr_press_gesture_classifier_tb;
  import afsr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RUN_LIMIT = 600000;
  localparam logic [19:0] CNT_MAX = 20'hFFFFF;

  typedef struct {
    logic [11:0] right;
    logic [11:0] left;
    logic [31:0] stamp;
    logic        link;
  } sample_t;

  typedef struct {
    logic [2:0] code;
    logic       tail;
  } gest_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [11:0] adc_right = '0;
  logic [11:0] adc_left = '0;
  logic [31:0] now_ms = '0;
  logic link_up = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [2:0] gesture;
  logic last;

  adaptive_fsr_press_gesture_classifier DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .adc_right(adc_right), .adc_left(adc_left), .now_ms(now_ms), .link_up(link_up),
    .out_valid(out_valid), .out_ready(out_ready), .gesture(gesture), .last(last)
  );

  always #2 clk = ~clk;

  // Predictor copy of the configuration registers.
  logic [31:0] r_long, r_hold, r_calib, r_factor, r_floor, r_window, r_init;

  // Predictor copy of the classifier state; index 0 is right, 1 is left.
  logic [12:0] thr [2];
  logic [31:0] idle_sum [2];
  logic [19:0] idle_cnt [2];
  logic [1:0]  pnow, pbefore;
  logic [31:0] press_start [2], release_at [2], first_at [2], hold_len [2];
  logic [7:0]  tally [2];
  logic [1:0]  long_seen, dbl_seen, first_ok;
  logic        handled;
  logic [31:0] hold_until;

  sample_t pending_samples[$];
  gest_t   gesture_fifo[$];
  logic [2:0] step_codes[$];

  int unsigned cycles = 0;
  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned gestures_seen = 0;
  int unsigned code_hits [8];
  bit idle_on = 1'b1;
  bit sender_hold = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_stall = 0;
  logic [31:0] clock_ms;

  function automatic void predictor_reset();
    r_long = 2000; r_hold = 500; r_calib = 10000; r_factor = 307;
    r_floor = 300; r_window = 500; r_init = 3600;
    for (int c = 0; c < 2; c++) begin
      thr[c] = 13'd3600; idle_sum[c] = 0; idle_cnt[c] = 0;
      press_start[c] = 0; release_at[c] = 0; first_at[c] = 0; hold_len[c] = 0;
      tally[c] = 0;
    end
    pnow = 0; pbefore = 0; long_seen = 0; dbl_seen = 0; first_ok = 0;
    handled = 1'b1; hold_until = 0;
  endfunction

  // Fold an unpressed sample into the idle mean, then refresh the threshold.
  function automatic void adapt_idle(int c, logic [11:0] s);
    logic [32:0] ns;
    logic [63:0] t;
    ns = {1'b0, idle_sum[c]} + 33'(s);
    if (idle_cnt[c] != CNT_MAX && !ns[32]) begin
      idle_sum[c] = ns[31:0];
      idle_cnt[c] = idle_cnt[c] + 1'b1;
    end
    if (idle_cnt[c] == 0) return;
    t = (64'(idle_sum[c]) * 64'(r_factor)) / (64'(idle_cnt[c]) * 64'd256);
    if (t < 64'(r_floor)) t = 64'(r_floor);
    if (t > 64'd8191) t = 64'd8191;
    thr[c] = t[12:0];
  endfunction

  function automatic void begin_holdoff(logic [31:0] now);
    pbefore = pnow;
    hold_until = now + r_hold;
  endfunction

  // Gesture decision for one sample; codes land in step_codes.
  function automatic void classify_sample(sample_t smp);
    logic [31:0] now;
    logic [11:0] s;
    logic [12:0] th;
    now = smp.stamp;
    if ((hold_until - now - 32'd1) < 32'd65535) return;
    for (int c = 0; c < 2; c++) begin
      s = (c == 0) ? smp.right : smp.left;
      th = (idle_cnt[c] == 0) ? r_init[12:0] : thr[c];
      pnow[c] = ({1'b0, s} >= th);
      if (!pnow[c]) adapt_idle(c, s);
    end
    if (!smp.link || now < r_calib) return;

    for (int c = 0; c < 2; c++) begin
      if (pnow[c] && !pbefore[c]) begin
        press_start[c] = now;
        pbefore = pnow;
        return;
      end
    end

    if (pnow[1] && pnow[0]) begin
      if ((now - press_start[0]) >= r_long && (now - press_start[1]) >= r_long) begin
        step_codes.push_back(G_ASSIST);
        begin_holdoff(now);
        long_seen = 2'b11;
        return;
      end
    end else begin
      if (pnow[1] && (now - press_start[1]) >= r_long) begin
        step_codes.push_back(G_VOL_DOWN);
        begin_holdoff(now);
        long_seen[1] = 1'b1;
        return;
      end
      if (pnow[0] && (now - press_start[0]) >= r_long) begin
        step_codes.push_back(G_VOL_UP);
        begin_holdoff(now);
        long_seen[0] = 1'b1;
        return;
      end
    end

    for (int c = 0; c < 2; c++) begin
      if (!pnow[c] && pbefore[c]) begin
        release_at[c] = now;
        hold_len[c] = now - press_start[c];
        if (!long_seen[c]) begin
          handled = 1'b0;
          if (tally[c] != 8'd255) tally[c] = tally[c] + 1'b1;
        end else begin
          handled = 1'b1;
          pbefore = pnow;
        end
        long_seen[c] = 1'b0;
      end
    end

    // A press that ran long never counts toward a double or single press.
    if (hold_len[1] > r_long || hold_len[0] > r_long || long_seen != 0) begin
      long_seen = 0;
      pbefore = pnow;
      hold_len[0] = 0;
      hold_len[1] = 0;
      return;
    end

    if (pnow != 0) return;

    if (!handled) begin
      for (int c = 0; c < 2; c++) begin
        if (!first_ok[c] && pbefore[c]) begin
          first_at[c] = now;
          first_ok[c] = 1'b1;
        end else if (!dbl_seen[c] && first_ok[c] && (now - first_at[c]) <= r_window &&
                     tally[c] >= 8'd2) begin
          dbl_seen[c] = 1'b1;
          step_codes.push_back(c == 0 ? G_NEXT : G_PREV);
          begin_holdoff(now);
          handled = 1'b1;
          tally[c] = 0;
          return;
        end
      end
    end

    // Single press once the release window has closed; clear the window state.
    for (int c = 0; c < 2; c++) begin
      if (!pnow[c] && (now - release_at[c]) >= r_window && first_ok[c]) begin
        if (tally[c] == 8'd1) step_codes.push_back(G_PLAY);
        handled = 1'b1;
        first_at[c] = 0;
        first_ok[c] = 1'b0;
        dbl_seen[c] = 1'b0;
        tally[c] = 0;
      end
    end
    pbefore = pnow;
  endfunction

  function automatic void predict_item(sample_t smp);
    gest_t g;
    step_codes.delete();
    classify_sample(smp);
    foreach (step_codes[i]) begin
      g.code = step_codes[i];
      g.tail = (i == step_codes.size() - 1);
      gesture_fifo.push_back(g);
    end
  endfunction

  // Driver: hold valid and payload until accepted, insert random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) begin
        predict_item('{adc_right, adc_left, now_ms, link_up});
        items_sent++;
      end
      if (tx_gap != 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (!sender_hold && pending_samples.size() != 0) begin
        sample_t nxt;
        nxt = pending_samples.pop_front();
        adc_right <= nxt.right;
        adc_left <= nxt.left;
        now_ms <= nxt.stamp;
        link_up <= nxt.link;
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 3);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, then check each accepted gesture item.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        gestures_seen++;
        code_hits[gesture]++;
        if (gesture_fifo.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected gesture item: code %0d last %0d", gesture, last);
        end else begin
          gest_t want;
          want = gesture_fifo.pop_front();
          if (want.code !== gesture || want.tail !== last) begin
            errors++;
            if (errors <= 10)
              $display("gesture item differs: expected code %0d last %0d, got code %0d last %0d",
                       want.code, want.tail, gesture, last);
          end
        end
      end
      if (rx_stall != 0) begin
        rx_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 4) == 0) rx_stall = $urandom_range(1, 3);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > RUN_LIMIT) begin
      $display("adaptive_fsr_press_gesture_classifier: mismatch");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_BITS-1:0];
    case (idx)
      REG_LONG_PRESS: r_long = val & 32'hFFFF;
      REG_HOLDOFF:    r_hold = val & 32'hFFFF;
      REG_CALIB:      r_calib = val & 32'hFFFFF;
      REG_FACTOR:     r_factor = val & 32'h3FF;
      REG_FLOOR:      r_floor = val & 32'hFFF;
      REG_WINDOW:     r_window = val & 32'hFFFF;
      REG_INIT_THR:   r_init = val & 32'h1FFF;
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(logic [31:0] lp, logic [31:0] ho, logic [31:0] ca,
                            logic [31:0] fa, logic [31:0] fl, logic [31:0] wi,
                            logic [31:0] it);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_HOLDOFF, ho);
    write_reg(REG_CALIB, ca);
    write_reg(REG_FACTOR, fa);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_WINDOW, wi);
    write_reg(REG_INIT_THR, it);
  endtask

  // Wait until every item went in and every gesture came out, then let the
  // last item (which may have produced nothing) finish its pass.
  task automatic drain();
    do @(posedge clk);
    while (pending_samples.size() != 0 || in_valid || tx_gap != 0 || gesture_fifo.size() != 0);
    repeat (80) @(posedge clk);
  endtask

  function automatic void push_sample(logic [11:0] r, logic [11:0] l, logic [31:0] t, logic k);
    sample_t s;
    s.right = r; s.left = l; s.stamp = t; s.link = k;
    pending_samples.push_back(s);
  endfunction

  function automatic logic [11:0] level(bit pressed);
    return pressed ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(0, 400));
  endfunction

  // Mostly press/release runs on one side, the other, both or neither, with
  // random levels; some noise items with arbitrary fields and timestamps.
  function automatic void make_samples(int count, int smin, int smax);
    int made, run, mask;
    bit lk;
    made = 0;
    while (made < count) begin
      if ($urandom_range(0, 9) == 0) begin
        push_sample(12'($urandom), 12'($urandom), $urandom, 1'($urandom));
        made++;
      end else begin
        mask = $urandom_range(0, 3);
        run = ($urandom_range(0, 3) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 5);
        lk = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < run && made < count; i++) begin
          clock_ms = clock_ms + $urandom_range(smin, smax);
          push_sample(level(mask[0]), level(mask[1]), clock_ms, lk);
          made++;
        end
      end
    end
  endfunction

  initial begin
    predictor_reset();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Defaults: the calibration period runs out partway through.
    clock_ms = 0;
    make_samples(250, 20, 80);
    drain();

    // Fast timing, timestamps wrap mid-phase; directed extremes first.
    set_config(40, 15, 0, 307, 300, 30, 3600);
    clock_ms = 32'hFFFF_FF00;
    push_sample(12'd0, 12'd0, 32'h0000_0000, 1'b1);
    push_sample(12'd4095, 12'd4095, 32'hFFFF_FFFF, 1'b1);
    push_sample(12'd4095, 12'd0, 32'h0000_0010, 1'b0);
    push_sample(12'd0, 12'd4095, 32'h0000_0020, 1'b1);
    push_sample(12'hAAA, 12'h555, 32'hAAAA_AAAA, 1'b1);
    push_sample(12'h555, 12'hAAA, 32'h5555_5555, 1'b0);
    push_sample(12'd0, 12'd0, 32'hFFFF_FE00, 1'b1);
    make_samples(170, 3, 12);
    // Stop sending mid-phase until every gesture has come back.
    wait (pending_samples.size() < 80);
    sender_hold = 1'b1;
    wait (!in_valid && gesture_fifo.size() == 0);
    repeat (60) @(posedge clk);
    sender_hold = 1'b0;
    make_samples(180, 3, 12);
    drain();

    // Lowest timing values with the highest threshold settings.
    set_config(1, 0, 0, 1023, 4095, 1, 8191);
    make_samples(150, 1, 3);
    drain();

    // Opposite extremes: everything counts as pressed.
    set_config(65535, 65535, 1048575, 0, 0, 65535, 0);
    clock_ms = 32'd1048000;
    make_samples(100, 200, 2000);
    drain();

    // Last part: no idling on either side.
    set_config(60, 25, 100, 512, 200, 45, 1000);
    idle_on = 1'b0;
    clock_ms = 0;
    make_samples(500, 2, 15);
    drain();

    if (gesture_fifo.size() != 0) errors++;
    $display("run covered %0d sample items and %0d gesture items over %0d cycles",
             items_sent, gestures_seen, cycles);
    $display("gesture counts: down %0d up %0d assist %0d next %0d prev %0d play %0d",
             code_hits[0], code_hits[1], code_hits[2], code_hits[3], code_hits[4],
             code_hits[5]);
    if (errors == 0) begin
      $display("adaptive_fsr_press_gesture_classifier: match");
    end else begin
      $display("adaptive_fsr_press_gesture_classifier: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: files.f
hdl/afsr_pkg.sv
hdl/afsr_ctrl.sv
hdl/afsr_datapath.sv
hdl/adaptive_fsr_press_gesture_classifier.sv
dv/adaptive_fsr_press_gesture_classifier_tb.sv
